// File: rtl/iotlb_pkg.sv
// shared constants, types and register codes of the iotlb timing block
package iotlb_pkg;

  localparam int MaxEntries = 32;
  localparam int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW       = $clog2(MaxEntries + 1);

  localparam int PageW    = 52;
  localparam int TimeW    = 64;
  localparam int LatW     = 32;
  localparam int CapW     = 6;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  localparam logic [CfgAddrW-1:0] RegEnabled     = CfgAddrW'(0);
  localparam logic [CfgAddrW-1:0] RegHitLatency  = CfgAddrW'(1);
  localparam logic [CfgAddrW-1:0] RegMissLatency = CfgAddrW'(2);
  localparam logic [CfgAddrW-1:0] RegCapacity    = CfgAddrW'(3);

  localparam logic [CapW-1:0] CapacityReset = CapW'(32);

  typedef struct packed {
    logic [PageW-1:0] page_number;
    logic [TimeW-1:0] current_time;
  } in_req_t;

  typedef struct packed {
    logic [TimeW-1:0] ready_time;
    logic             hit;
    logic             counted;
    logic [TimeW-1:0] lookup_total;
    logic [TimeW-1:0] hit_total;
    logic [TimeW-1:0] miss_total;
    logic [TimeW-1:0] latency_total;
  } out_rsp_t;

  typedef struct packed {
    logic            enabled;
    logic [LatW-1:0] hit_ticks;
    logic [LatW-1:0] miss_ticks;
    logic [CapW-1:0] tlb_capacity;
  } cfg_t;

  typedef struct packed {
    logic            lookup;
    logic            clear;
    logic [CapW-1:0] capacity;
  } tbl_ctl_t;

endpackage

// File: rtl/iotlb_table.sv
// fully associative tag store with lru ranks and a fill count
module iotlb_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  iotlb_pkg::tbl_ctl_t         ctl_i,
  input  logic [iotlb_pkg::PageW-1:0] page_i,
  output logic                        hit_o
);
  import iotlb_pkg::*;

  logic [PageW-1:0] tag_q [MaxEntries];
  logic [IdxW-1:0]  age_q [MaxEntries];
  logic [IdxW-1:0]  age_d [MaxEntries];
  logic [CntW-1:0]  used_q, used_d;

  logic [CntW-1:0]       cap;
  logic [MaxEntries-1:0] valid, match, sel;
  logic [IdxW-1:0]       old_age;
  logic                  hit, free_ins, do_upd;
  logic [CntW-1:0]       thresh;

  always_comb begin
    if (int'(ctl_i.capacity) > MaxEntries) begin
      cap = CntW'(MaxEntries);
    end else begin
      cap = CntW'(ctl_i.capacity);
    end
  end

  // entries are filled in order and only cleared all together,
  // so the valid ones are exactly those below the fill count
  always_comb begin
    old_age = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      valid[i] = CntW'(i) < used_q;
      match[i] = valid[i] && (tag_q[i] == page_i);
      if (match[i]) begin
        old_age = old_age | age_q[i];
      end
    end
  end

  assign hit      = |match;
  assign free_ins = !hit && (used_q < cap);
  assign do_upd   = ctl_i.lookup && (hit || (cap != '0));

  // ranks of valid entries form 0..used-1, so the victim is the one
  // holding rank used-1 and everything below the threshold ages by one
  always_comb begin
    if (hit) begin
      thresh = CntW'(old_age);
    end else if (free_ins) begin
      thresh = used_q;
    end else begin
      thresh = used_q - 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < MaxEntries; i++) begin
      if (hit) begin
        sel[i] = match[i];
      end else if (free_ins) begin
        sel[i] = (CntW'(i) == used_q);
      end else begin
        sel[i] = valid[i] && (CntW'(age_q[i]) == (used_q - 1'b1));
      end
      if (sel[i]) begin
        age_d[i] = '0;
      end else if (valid[i] && (CntW'(age_q[i]) < thresh)) begin
        age_d[i] = age_q[i] + 1'b1;
      end else begin
        age_d[i] = age_q[i];
      end
    end
  end

  always_comb begin
    used_d = used_q;
    if (ctl_i.clear) begin
      used_d = '0;
    end else if (do_upd && free_ins) begin
      used_d = used_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      for (int i = 0; i < MaxEntries; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      used_q <= used_d;
      if (do_upd) begin
        for (int i = 0; i < MaxEntries; i++) begin
          age_q[i] <= age_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_upd && !hit) begin
      for (int i = 0; i < MaxEntries; i++) begin
        if (sel[i]) begin
          tag_q[i] <= page_i;
        end
      end
    end
  end

  assign hit_o = hit;

endmodule

// File: rtl/iotlb_timing.sv
// serialized port timing and statistic counters
module iotlb_timing (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  iotlb_pkg::cfg_t             cfg_i,
  input  logic                        fire_i,
  input  logic                        hit_i,
  input  logic [iotlb_pkg::TimeW-1:0] now_i,
  output logic                        active_o,
  output iotlb_pkg::out_rsp_t         rsp_o
);
  import iotlb_pkg::*;

  logic [TimeW-1:0] port_free_q, port_free_d;
  logic [TimeW-1:0] lookup_q, lookup_d;
  logic [TimeW-1:0] hits_q, hits_d;
  logic [TimeW-1:0] misses_q, misses_d;
  logic [TimeW-1:0] lat_sum_q, lat_sum_d;

  logic             active;
  logic [LatW-1:0]  lat;
  logic [TimeW-1:0] start, ready;
  logic [TimeW:0]   ready_sum, lat_sum_sum;

  assign active = cfg_i.enabled && ((cfg_i.hit_ticks != '0) || (cfg_i.miss_ticks != '0));
  assign lat    = hit_i ? cfg_i.hit_ticks : cfg_i.miss_ticks;
  assign start  = (now_i > port_free_q) ? now_i : port_free_q;

  // saturate on carry out
  assign ready_sum   = {1'b0, start} + (TimeW + 1)'(lat);
  assign ready       = ready_sum[TimeW] ? '1 : ready_sum[TimeW-1:0];
  assign lat_sum_sum = {1'b0, lat_sum_q} + (TimeW + 1)'(lat);

  assign port_free_d = ready;
  assign lookup_d    = lookup_q + 1'b1;
  assign hits_d      = hit_i ? hits_q + 1'b1 : hits_q;
  assign misses_d    = hit_i ? misses_q : misses_q + 1'b1;
  assign lat_sum_d   = lat_sum_sum[TimeW] ? '1 : lat_sum_sum[TimeW-1:0];

  always_comb begin
    if (active) begin
      rsp_o.ready_time    = ready;
      rsp_o.hit           = hit_i;
      rsp_o.counted       = 1'b1;
      rsp_o.lookup_total  = lookup_d;
      rsp_o.hit_total     = hits_d;
      rsp_o.miss_total    = misses_d;
      rsp_o.latency_total = lat_sum_d;
    end else begin
      rsp_o.ready_time    = now_i;
      rsp_o.hit           = 1'b0;
      rsp_o.counted       = 1'b0;
      rsp_o.lookup_total  = lookup_q;
      rsp_o.hit_total     = hits_q;
      rsp_o.miss_total    = misses_q;
      rsp_o.latency_total = lat_sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_free_q <= '0;
      lookup_q    <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      lat_sum_q   <= '0;
    end else if (fire_i && active) begin
      port_free_q <= port_free_d;
      lookup_q    <= lookup_d;
      hits_q      <= hits_d;
      misses_q    <= misses_d;
      lat_sum_q   <= lat_sum_d;
    end
  end

  assign active_o = active;

endmodule

// File: rtl/iotlb_lru_with_port_timing.sv
// top level: request register, iotlb lookup and timing, result register
// an accepted request waits in the request register, then is looked up, timed and captured in the result register
// one request per cycle while the output is not stalled; each lookup sees the lru table as the lookup before left it
// reset clears the table fill count, port time and counters at once; no clearing pass
// configuration resets to enabled, zero latencies and capacity 32
module iotlb_lru_with_port_timing (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  iotlb_pkg::in_req_t             in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output iotlb_pkg::out_rsp_t            out_rsp_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [iotlb_pkg::CfgAddrW-1:0] cfg_index_i,
  input  logic [iotlb_pkg::CfgDataW-1:0] cfg_data_i
);
  import iotlb_pkg::*;

  cfg_t     cfg_q, cfg_d;
  logic     pipe_valid_q, pipe_valid_d;
  in_req_t  pipe_req_q;
  logic     out_valid_q, out_valid_d;
  out_rsp_t out_rsp_q, rsp;

  logic     fire, in_acc, cfg_wr, active, hit;
  tbl_ctl_t tbl_ctl;

  assign fire   = pipe_valid_q && (!out_valid_q || !out_stall_i);
  assign in_acc = in_valid_i && !in_stall_o;
  assign cfg_wr = cfg_valid_i && cfg_ready_o;

  assign in_stall_o  = pipe_valid_q && !fire;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (cfg_index_i)
        RegEnabled:     cfg_d.enabled      = cfg_data_i[0];
        RegHitLatency:  cfg_d.hit_ticks    = cfg_data_i[LatW-1:0];
        RegMissLatency: cfg_d.miss_ticks   = cfg_data_i[LatW-1:0];
        RegCapacity:    cfg_d.tlb_capacity = cfg_data_i[CapW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  assign tbl_ctl.lookup   = fire && active;
  assign tbl_ctl.clear    = cfg_wr && (cfg_index_i == RegCapacity);
  assign tbl_ctl.capacity = cfg_q.tlb_capacity;

  iotlb_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (tbl_ctl),
    .page_i (pipe_req_q.page_number),
    .hit_o  (hit)
  );

  iotlb_timing u_timing (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .fire_i   (fire),
    .hit_i    (hit),
    .now_i    (pipe_req_q.current_time),
    .active_o (active),
    .rsp_o    (rsp)
  );

  always_comb begin
    pipe_valid_d = pipe_valid_q;
    if (in_acc) begin
      pipe_valid_d = 1'b1;
    end else if (fire) begin
      pipe_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_valid_q       <= 1'b0;
      out_valid_q        <= 1'b0;
      cfg_q.enabled      <= 1'b1;
      cfg_q.hit_ticks    <= '0;
      cfg_q.miss_ticks   <= '0;
      cfg_q.tlb_capacity <= CapacityReset;
    end else begin
      pipe_valid_q <= pipe_valid_d;
      out_valid_q  <= out_valid_d;
      cfg_q        <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pipe_req_q <= in_req_i;
    end
    if (fire) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// File: sim/tb_iotlb_lru_with_port_timing.sv
// testbench for the iotlb lru lookup block with serialized port timing
module tb_iotlb_lru_with_port_timing;
  timeunit 1ns;
  timeprecision 1ps;

  import iotlb_pkg::*;

  localparam logic [CfgAddrW-1:0] RegUnused = CfgAddrW'(9);
  localparam int CycleLimit = 400000;
  localparam logic [PageW-1:0] PageA = PageW'('h123);
  localparam logic [PageW-1:0] PageB = PageW'('h4_5600);
  localparam logic [PageW-1:0] PageC = PageW'('h789_abcd);

  class tlb_timing_checker;
    // mirrored configuration
    logic            enabled;
    logic [LatW-1:0] hit_lat;
    logic [LatW-1:0] miss_lat;
    logic [CapW-1:0] capacity;
    // mirrored lru table and port state
    logic [PageW-1:0] tag_q[MaxEntries];
    bit               valid_q[MaxEntries];
    logic [IdxW-1:0]  age_q[MaxEntries];
    logic [TimeW-1:0] port_free;
    logic [TimeW-1:0] n_lookup, n_hit, n_miss, lat_sum;
    out_rsp_t         pending_rsp[$];
    int               n_errors;
    int               n_checked;

    function new();
      enabled   = 1'b1;
      hit_lat   = '0;
      miss_lat  = '0;
      capacity  = CapacityReset;
      port_free = '0;
      n_lookup  = '0;
      n_hit     = '0;
      n_miss    = '0;
      lat_sum   = '0;
      n_errors  = 0;
      n_checked = 0;
      clear_table();
    endfunction

    function void clear_table();
      for (int i = 0; i < MaxEntries; i++) begin
        tag_q[i]   = '0;
        valid_q[i] = 1'b0;
        age_q[i]   = '0;
      end
    endfunction

    function void write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] d);
      case (idx)
        RegEnabled:     enabled = d[0];
        RegHitLatency:  hit_lat = d[LatW-1:0];
        RegMissLatency: miss_lat = d[LatW-1:0];
        RegCapacity: begin
          capacity = d[CapW-1:0];
          clear_table();
        end
        default: ;
      endcase
    endfunction

    function logic [TimeW-1:0] sat_add(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
      logic [TimeW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TimeW] ? '1 : s[TimeW-1:0];
    endfunction

    // returns 1 on a hit and updates lru order
    function bit tlb_lookup(logic [PageW-1:0] page);
      int cap, used, free_slot, victim;
      logic [IdxW-1:0] old;
      cap = (capacity > MaxEntries) ? MaxEntries : int'(capacity);
      used = 0;
      free_slot = -1;
      victim = -1;
      if (cap == 0) return 1'b0;
      for (int i = 0; i < MaxEntries; i++) begin
        if (valid_q[i] && tag_q[i] == page) begin
          old = age_q[i];
          for (int j = 0; j < MaxEntries; j++)
            if (valid_q[j] && age_q[j] < old) age_q[j] = age_q[j] + 1'b1;
          age_q[i] = '0;
          return 1'b1;
        end
      end
      for (int i = 0; i < MaxEntries; i++) begin
        if (valid_q[i]) begin
          used++;
          if (victim < 0 || age_q[i] > age_q[victim]) victim = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (used < cap && free_slot >= 0) begin
        for (int i = 0; i < MaxEntries; i++)
          if (valid_q[i]) age_q[i] = age_q[i] + 1'b1;
        valid_q[free_slot] = 1'b1;
        tag_q[free_slot]   = page;
        age_q[free_slot]   = '0;
      end else if (victim >= 0) begin
        for (int i = 0; i < MaxEntries; i++)
          if (valid_q[i] && i != victim) age_q[i] = age_q[i] + 1'b1;
        tag_q[victim] = page;
        age_q[victim] = '0;
      end
      return 1'b0;
    endfunction

    function void note_request(in_req_t r);
      out_rsp_t         e;
      bit               hit;
      logic [LatW-1:0]  lat;
      logic [TimeW-1:0] start;
      e = '0;
      e.ready_time = r.current_time;
      if (enabled && (hit_lat != 0 || miss_lat != 0)) begin
        hit   = tlb_lookup(r.page_number);
        lat   = hit ? hit_lat : miss_lat;
        start = (r.current_time > port_free) ? r.current_time : port_free;
        port_free = sat_add(start, {32'b0, lat});
        e.ready_time = port_free;
        e.hit     = hit;
        e.counted = 1'b1;
        n_lookup++;
        if (hit) n_hit++;
        else n_miss++;
        lat_sum = sat_add(lat_sum, {32'b0, lat});
      end
      e.lookup_total  = n_lookup;
      e.hit_total     = n_hit;
      e.miss_total    = n_miss;
      e.latency_total = lat_sum;
      pending_rsp.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      n_errors++;
    endtask

    task cmp(string name, logic [TimeW-1:0] got, logic [TimeW-1:0] want);
      if (got !== want)
        report($sformatf("response %0d %s: got %0h, want %0h", n_checked, name, got, want));
    endtask

    task check_response(out_rsp_t got);
      out_rsp_t e;
      if (pending_rsp.size() == 0) begin
        report($sformatf("response with no pending request, ready_time %0h", got.ready_time));
        return;
      end
      e = pending_rsp.pop_front();
      n_checked++;
      cmp("ready_time", got.ready_time, e.ready_time);
      cmp("hit", got.hit, e.hit);
      cmp("counted", got.counted, e.counted);
      cmp("lookup_total", got.lookup_total, e.lookup_total);
      cmp("hit_total", got.hit_total, e.hit_total);
      cmp("miss_total", got.miss_total, e.miss_total);
      cmp("latency_total", got.latency_total, e.latency_total);
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_req_t             in_req_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_rsp_t            out_rsp_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  tlb_timing_checker sb;
  bit                quiet;
  int                cycle_cnt;
  logic [TimeW-1:0]  now_t;
  logic [PageW-1:0]  pool[64];

  iotlb_lru_with_port_timing uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver side stalls at random
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && !quiet && ($urandom_range(99) < 28);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_response(out_rsp_o);
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic in_req_t mk_req(logic [PageW-1:0] pg, logic [TimeW-1:0] t);
    in_req_t r;
    r.page_number  = pg;
    r.current_time = t;
    return r;
  endfunction

  task send_req(in_req_t r);
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
    if (!quiet && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // hold off new requests until every result is back
  task wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task write_cfg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] d);
    wait_idle();
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, d);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task configure(bit en, logic [LatW-1:0] hl, logic [LatW-1:0] ml, int cap);
    write_cfg(RegEnabled, CfgDataW'(en));
    write_cfg(RegHitLatency, hl);
    write_cfg(RegMissLatency, ml);
    write_cfg(RegCapacity, CfgDataW'(cap));
    now_t = sb.port_free;
  endtask

  // mostly pages from a small working set, some stray pages
  task run_phase(int n, int pool_n, bit wild, int unsigned step_max);
    in_req_t r;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 85) r.page_number = pool[$urandom_range(pool_n - 1)];
      else r.page_number = PageW'({$urandom(), $urandom()});
      now_t = now_t + $urandom_range(0, step_max);
      r.current_time = now_t;
      if (wild) begin
        case ($urandom_range(2))
          0: r.current_time = {$urandom(), $urandom()};
          1: r.current_time = '1 - $urandom_range(0, 500);
          default: ;
        endcase
      end
      send_req(r);
    end
  endtask

  initial begin
    int rnd_cap;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    quiet       = 1'b0;
    now_t       = '0;
    sb = new();
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < 64; i++) pool[i] = PageW'({$urandom(), $urandom()});
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: zero latencies, so requests pass straight through
    send_req(mk_req('0, '0));
    send_req(mk_req('1, '1));

    // two entries: hit, lru eviction, serialized port
    configure(1'b1, 5, 20, 2);
    send_req(mk_req(PageA, 100));
    send_req(mk_req(PageB, 100));
    send_req(mk_req(PageA, 100));
    send_req(mk_req(PageC, 100));
    send_req(mk_req(PageB, 100));
    send_req(mk_req(PageC, 100));
    send_req(mk_req('1, 100));
    send_req(mk_req('0, 100));
    send_req(mk_req('1, 100));

    // zero capacity never stores
    write_cfg(RegCapacity, 0);
    send_req(mk_req(PageA, 200));
    send_req(mk_req(PageA, 200));

    // capacity above the table size saturates
    write_cfg(RegCapacity, 63);
    send_req(mk_req(PageA, 300));
    send_req(mk_req(PageA, 300));

    write_cfg(RegHitLatency, 0);
    write_cfg(RegMissLatency, 0);
    send_req(mk_req(PageA, 400));
    // only a miss latency: hits are still counted
    write_cfg(RegMissLatency, 12);
    send_req(mk_req(PageA, 400));
    send_req(mk_req(PageB, 400));

    write_cfg(RegEnabled, 0);
    send_req(mk_req(PageA, 500));
    write_cfg(RegUnused, 1);
    send_req(mk_req(PageA, 500));
    write_cfg(RegEnabled, 1);
    write_cfg(RegHitLatency, '1);
    write_cfg(RegMissLatency, '1);
    send_req(mk_req(PageA, 600));
    send_req(mk_req(PageB, 600));

    configure(1'b1, 2, 30, 8);
    run_phase(300, 12, 1'b0, 40);

    quiet = 1'b1;
    configure(1'b1, 1, 100, 32);
    run_phase(300, 40, 1'b0, 120);
    quiet = 1'b0;

    configure(1'b1, 0, 7, 1);
    run_phase(150, 3, 1'b0, 10);

    configure(1'b1, 3, 9, 0);
    run_phase(100, 6, 1'b0, 12);

    rnd_cap = $urandom_range(2, 31);
    configure(1'b1, $urandom(), $urandom(), rnd_cap);
    run_phase(120, rnd_cap + 4, 1'b0, 32'hffff_ffff);
    wait_idle();
    run_phase(130, rnd_cap + 4, 1'b0, 32'hffff_ffff);

    // disabled: random times pass through
    configure(1'b0, 5, 5, 32);
    run_phase(150, 64, 1'b1, 50);

    configure(1'b1, 4, 4, 16);
    run_phase(250, 20, 1'b0, 10);

    // times near the top drive ready time into saturation
    configure(1'b1, 6, '1, 32);
    run_phase(250, 40, 1'b1, 1000);

    wait_idle();
    if (sb.n_errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/iotlb_pkg.sv
rtl/iotlb_table.sv
rtl/iotlb_timing.sv
rtl/iotlb_lru_with_port_timing.sv
sim/tb_iotlb_lru_with_port_timing.sv
